@@ rtl/core/lfps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, widths and constants of the led fade pattern sequencer.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4;
  localparam int unsigned TABLE_ENTRIES_MAX = 4;
  localparam int unsigned TICK_US           = 5;
  localparam int unsigned US_PER_MS         = 1000;

  localparam int unsigned ELAPSED_W   = 28;
  localparam int unsigned HALF_MS_W   = 16;
  localparam int unsigned HALF_W      = 26;
  localparam int unsigned STEP_W      = 26;
  localparam int unsigned ON_W        = 16;
  localparam int unsigned BLINK_W     = 8;
  localparam int unsigned ENTRY_IDX_W = 2;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned NUM_COLOURS = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD  = 3'd0,
    REG_ENTRY_COUNT = 3'd1,
    REG_ENTRY_0     = 3'd2,
    REG_ENTRY_1     = 3'd3,
    REG_ENTRY_2     = 3'd4,
    REG_ENTRY_3     = 3'd5
  } cfg_reg_e;

  // colour_en[0] green, [1] blue, [2] red
  typedef struct packed {
    logic                   led;
    logic [NUM_COLOURS-1:0] colour_en;
    logic [BLINK_W-1:0]     blink_count;
    logic [HALF_MS_W-1:0]   half_ms;
  } entry_word_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  entry_count;
    entry_word_t         word;
  } cfg_view_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic enable;
  } tick_t;

  typedef struct packed {
    logic            led_select;
    logic [ON_W-1:0] green_on_time;
    logic [ON_W-1:0] blue_on_time;
    logic [ON_W-1:0] red_on_time;
  } result_t;

  function automatic logic [HALF_W-1:0] half_us_of(input logic [HALF_MS_W-1:0] ms);
    return HALF_W'(ms) * HALF_W'(US_PER_MS);
  endfunction

endpackage

@@ rtl/core/lfps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lfps_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lfps_serial_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_serial_div
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module lfps_serial_div #(
  parameter int unsigned DVD_W = lfps_pkg::ELAPSED_W,
  parameter int unsigned DVS_W = lfps_pkg::STEP_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output lfps_pkg::div_stat_t stat_o,
  output logic [DVD_W-1:0]   quotient_o,
  output logic [DVS_W-1:0]   remainder_o
);
  import lfps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  div_stat_t        stat_q;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      cnt_q  <= '0;
    end else begin
      stat_q.done <= stat_q.busy && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        stat_q.busy <= 1'b1;
        cnt_q       <= CNT_W'(DVD_W);
      end else if (stat_q.busy) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          stat_q.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (stat_q.busy) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign stat_o      = stat_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ rtl/core/lfps_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_cfg_regs
// Configuration registers and selection of the current pattern entry.
// ----------------------------------------------------------------------------
module lfps_cfg_regs #(
  parameter int unsigned TABLE_ENTRIES = lfps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lfps_pkg::ENTRY_IDX_W-1:0]    entry_idx_i,
  output lfps_pkg::cfg_view_t                 view_o
);
  import lfps_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [COUNT_W-1:0]  count_q;
  entry_word_t         entry_q [TABLE_ENTRIES];
  cfg_reg_e            reg_sel;
  entry_word_t         cur_word;

  assign reg_sel = cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_W'(1000);
      count_q  <= COUNT_W'(1);
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
        entry_q[e] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (reg_sel) inside
        REG_PWM_PERIOD:  period_q <= cfg_data_i[PERIOD_W-1:0];
        REG_ENTRY_COUNT: count_q  <= cfg_data_i[COUNT_W-1:0];
        REG_ENTRY_0, REG_ENTRY_1, REG_ENTRY_2, REG_ENTRY_3: begin
          // entries beyond the table depth are dropped
          for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (cfg_idx_i == CFG_IDX_W'(REG_ENTRY_0) + CFG_IDX_W'(e)) begin
              entry_q[e] <= entry_word_t'(cfg_data_i);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_word = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (entry_idx_i == ENTRY_IDX_W'(e)) begin
        cur_word = entry_q[e];
      end
    end
  end

  // a zero pwm period counts as one
  assign view_o.period      = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign view_o.entry_count = count_q;
  assign view_o.word        = cur_word;

endmodule

@@ rtl/core/led_fade_pattern_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_fade_pattern_sequencer_core
// Steps an rgb breathing pattern through a small table, one tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i carries one 5 us tick per transaction. A tick with enable low is
//   taken and yields nothing. An enabled tick advances the
//   pattern and yields one transaction on result_o: the led select and the
//   green, blue and red on-times in microseconds.
//   An enabled tick runs two 28-step bit-serial divisions through one
//   shared divider (fade step, then elapsed time modulo step) before its
//   result is loaded. tick_i is ready again from the edge that loads the
//   result, so no new tick is taken before the last one is through.
//   The result sits in an output register; when the receiver stalls the next
//   tick is still taken and worked on, and its result waits until the
//   register frees up.
//   Reset clears the pattern position and on-times and loads the register
//   defaults (pwm period 1000 us, one entry, all entries zero).
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
//   user must write it while no tick is in flight; the block does not check.
// ----------------------------------------------------------------------------
module led_fade_pattern_sequencer_core #(
  parameter int unsigned TABLE_ENTRIES = lfps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lfps_if.sink                            tick_i,
  lfps_if.source                          result_o
);
  import lfps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HALF_A,
    ST_BOUND,
    ST_HALF_B,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [ELAPSED_W-1:0]   elapsed_q;
  logic                   rising_q;
  logic [BLINK_W-1:0]     blinks_q;
  logic [ENTRY_IDX_W-1:0] entry_idx_q;
  logic [ON_W-1:0]        on_q [NUM_COLOURS];
  logic                   out_valid_q;

  logic [HALF_W-1:0]      half_q;
  logic [STEP_W-1:0]      step_q;
  result_t                res_q;

  cfg_view_t              view;
  logic [HALF_W-1:0]      half_cur;
  logic                   at_half;
  logic                   at_end;
  logic [BLINK_W-1:0]     blinks_inc;
  logic [COUNT_W-1:0]     idx_inc;
  logic [ENTRY_IDX_W-1:0] idx_next;
  logic                   out_free;
  logic                   tick_take;

  logic                   div_start;
  logic [ELAPSED_W-1:0]   div_dividend;
  logic [STEP_W-1:0]      div_divisor;
  div_stat_t              div_stat;
  logic [ELAPSED_W-1:0]   div_quo;
  logic [STEP_W-1:0]      div_rem;

  lfps_cfg_regs #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .entry_idx_i (entry_idx_q),
    .view_o      (view)
  );

  lfps_serial_div #(
    .DVD_W(ELAPSED_W),
    .DVS_W(STEP_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign half_cur   = half_us_of(view.word.half_ms);
  assign at_half    = elapsed_q == ELAPSED_W'(half_q);
  assign at_end     = elapsed_q == ELAPSED_W'({half_q, 1'b0});
  assign blinks_inc = blinks_q + BLINK_W'(1);
  assign idx_inc    = COUNT_W'(entry_idx_q) + COUNT_W'(1);

  // wrap at the programmed count or the table depth, whichever comes first
  always_comb begin
    if (idx_inc >= view.entry_count || idx_inc >= COUNT_W'(TABLE_ENTRIES) ||
        idx_inc >= COUNT_W'(TABLE_ENTRIES_MAX)) begin
      idx_next = '0;
    end else begin
      idx_next = idx_inc[ENTRY_IDX_W-1:0];
    end
  end

  assign div_start    = (state_q == ST_STEP_GO) || (state_q == ST_MOD_GO);
  assign div_dividend = (state_q == ST_STEP_GO) ? ELAPSED_W'(half_q) : elapsed_q;
  assign div_divisor  = (state_q == ST_STEP_GO) ? STEP_W'(view.period) : step_q;

  assign out_free  = !out_valid_q || result_o.ready;
  assign tick_take = tick_i.valid && (state_q == ST_IDLE);

  assign tick_i.ready     = (state_q == ST_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      rising_q    <= 1'b1;
      blinks_q    <= '0;
      entry_idx_q <= '0;
      for (int k = 0; k < NUM_COLOURS; k++) begin
        on_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (tick_take && tick_i.payload.enable) begin
            state_q <= ST_HALF_A;
          end
        end
        ST_HALF_A: state_q <= ST_BOUND;
        ST_BOUND: begin
          if (at_half) begin
            rising_q <= 1'b0;
          end else if (at_end) begin
            elapsed_q <= '0;
            rising_q  <= 1'b1;
            if (blinks_inc == view.word.blink_count) begin
              blinks_q    <= '0;
              entry_idx_q <= idx_next;
              for (int k = 0; k < NUM_COLOURS; k++) begin
                on_q[k] <= '0;
              end
            end else begin
              blinks_q <= blinks_inc;
            end
          end
          state_q <= ST_HALF_B;
        end
        ST_HALF_B:  state_q <= ST_STEP_GO;
        ST_STEP_GO: state_q <= ST_STEP_WAIT;
        ST_STEP_WAIT: begin
          if (div_stat.done) begin
            state_q <= ST_MOD_GO;
          end
        end
        ST_MOD_GO: state_q <= ST_MOD_WAIT;
        ST_MOD_WAIT: begin
          if (div_stat.done) begin
            if (div_rem == '0) begin
              for (int k = 0; k < NUM_COLOURS; k++) begin
                if (view.word.colour_en[k]) begin
                  if (rising_q) begin
                    if (on_q[k] != '1) begin
                      on_q[k] <= on_q[k] + ON_W'(1);
                    end
                  end else if (on_q[k] != '0) begin
                    on_q[k] <= on_q[k] - ON_W'(1);
                  end
                end
              end
            end
            elapsed_q <= elapsed_q + ELAPSED_W'(TICK_US);
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HALF_A || state_q == ST_HALF_B) begin
      half_q <= half_cur;
    end
    // a step below one is held at one
    if (state_q == ST_STEP_WAIT && div_stat.done) begin
      step_q <= (div_quo == '0) ? STEP_W'(1) : div_quo[STEP_W-1:0];
    end
    if (state_q == ST_EMIT && out_free) begin
      res_q.led_select    <= view.word.led;
      res_q.green_on_time <= on_q[0];
      res_q.blue_on_time  <= on_q[1];
      res_q.red_on_time   <= on_q[2];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD_GO) |-> (step_q != '0))
    else $error("fade step is zero at modulo start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    COUNT_W'(entry_idx_q) < COUNT_W'(TABLE_ENTRIES))
    else $error("entry index beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_STEP_WAIT || state_q == ST_MOD_WAIT))
    else $error("divider result arrived outside a wait state");

endmodule
